// ===== rtl/nwmc_pkg.sv =====
package nwmc_pkg;

	localparam int HOUR_W     = 5;
	localparam int MINUTE_W   = 6;
	localparam int SECOND_W   = 6;
	localparam int TOD_W      = 11;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int MARK_W     = 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NIGHT_START = 2'd0,
		REG_NIGHT_END   = 2'd1,
		REG_AUTO_NIGHT  = 2'd2,
		REG_CLOCK_VALID = 2'd3
	} reg_index_t;

	typedef enum logic {
		CMD_TICK   = 1'b0,
		CMD_MANUAL = 1'b1
	} command_t;

	typedef enum logic [MARK_W-1:0] {
		MARK_NONE     = 2'd0,
		MARK_MINUTE   = 2'd1,
		MARK_HOUR     = 2'd2,
		MARK_MIDNIGHT = 2'd3
	} mark_t;

	typedef struct packed {
		logic [TOD_W-1:0] night_start;
		logic [TOD_W-1:0] night_end;
		logic             auto_night;
		logic             clock_valid;
	} cfg_t;

	typedef struct packed {
		logic night_flag;
		logic override_pending;
	} flags_t;

	typedef struct packed {
		logic                command;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
		logic                manual_night;
	} item_t;

	typedef struct packed {
		logic              night_changed;
		logic              night_on;
		logic [MARK_W-1:0] time_mark;
		logic              night_status;
	} result_t;

endpackage

// ===== rtl/nwmc_if.sv =====
interface nwmc_in_if;
	import nwmc_pkg::*;
	logic                valid;
	logic                ready;
	logic                command;
	logic [HOUR_W-1:0]   hour;
	logic [MINUTE_W-1:0] minute;
	logic [SECOND_W-1:0] second;
	logic                manual_night;

	modport source (output valid, command, hour, minute, second, manual_night, input ready);
	modport sink   (input valid, command, hour, minute, second, manual_night, output ready);
endinterface

interface nwmc_out_if;
	import nwmc_pkg::*;
	logic              valid;
	logic              ready;
	logic              night_changed;
	logic              night_on;
	logic [MARK_W-1:0] time_mark;
	logic              night_status;

	modport source (output valid, night_changed, night_on, time_mark, night_status, input ready);
	modport sink   (input valid, night_changed, night_on, time_mark, night_status, output ready);
endinterface

interface nwmc_cfg_if;
	import nwmc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/nwmc_cfg_regs.sv =====
module nwmc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [nwmc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [nwmc_pkg::CFG_DATA_W-1:0] wr_data,
	output nwmc_pkg::cfg_t                  cfg
);
	import nwmc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.night_start <= '0;
			cfg_q.night_end   <= '0;
			cfg_q.auto_night  <= 1'b1;
			cfg_q.clock_valid <= 1'b0;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_NIGHT_START: cfg_q.night_start <= wr_data[TOD_W-1:0];
				REG_NIGHT_END:   cfg_q.night_end   <= wr_data[TOD_W-1:0];
				REG_AUTO_NIGHT:  cfg_q.auto_night  <= wr_data[0];
				REG_CLOCK_VALID: cfg_q.clock_valid <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/nwmc_step.sv =====
module nwmc_step (
	input  nwmc_pkg::cfg_t    cfg,
	input  nwmc_pkg::flags_t  flags,
	input  nwmc_pkg::item_t   item,
	output nwmc_pkg::flags_t  flags_next,
	output nwmc_pkg::result_t res
);
	import nwmc_pkg::*;

	logic [TOD_W-1:0] tod;
	logic             sched;
	logic             tick_changed;
	flags_t           tick_flags;
	mark_t            mark;

	// hour*60 = hour*64 - hour*4, never exceeds 11 bits
	assign tod = ({item.hour, 6'b0} - {4'b0, item.hour, 2'b0}) + TOD_W'(item.minute);

	always_comb begin
		if (cfg.night_start == cfg.night_end) begin
			sched = 1'b0;
		end else if (cfg.night_start < cfg.night_end) begin
			sched = (tod >= cfg.night_start) && (tod < cfg.night_end);
		end else begin
			// window wraps past midnight
			sched = (tod >= cfg.night_start) || (tod < cfg.night_end);
		end
	end

	always_comb begin
		tick_flags   = flags;
		tick_changed = 1'b0;
		if (cfg.auto_night) begin
			if (sched == flags.night_flag) begin
				tick_flags.override_pending = 1'b0;
			end else if (!flags.override_pending) begin
				tick_flags.night_flag = sched;
				tick_changed          = 1'b1;
			end
		end
	end

	always_comb begin
		if (item.second != '0) begin
			mark = MARK_NONE;
		end else if (item.minute != '0) begin
			mark = MARK_MINUTE;
		end else if (item.hour != '0) begin
			mark = MARK_HOUR;
		end else begin
			mark = MARK_MIDNIGHT;
		end
	end

	always_comb begin
		flags_next        = flags;
		res.night_changed = 1'b0;
		res.time_mark     = MARK_NONE;
		case (command_t'(item.command))
			CMD_TICK: begin
				flags_next        = tick_flags;
				res.night_changed = tick_changed;
				res.time_mark     = mark;
			end
			CMD_MANUAL: begin
				if (item.manual_night != flags.night_flag) begin
					flags_next.night_flag       = item.manual_night;
					flags_next.override_pending = 1'b1;
					res.night_changed           = 1'b1;
				end
			end
			default: ;
		endcase
		res.night_on     = flags_next.night_flag;
		res.night_status = flags_next.night_flag & cfg.clock_valid;
	end

endmodule

// ===== rtl/night_window_mode_controller_unit.sv =====
// Night-window mode controller. Items arrive on the item channel: a clock tick
// (command 0, with hour/minute/second) or a manual request (command 1, with
// manual_night). Every item produces exactly one result transaction carrying
// night_changed, night_on, time_mark and night_status. The block is a two-stage
// pipeline (input register, result register) and takes one item per cycle;
// an accepted item waits in the input register, and its result then moves
// into the result register that drives the result channel. Only the result
// channel's ready slows it down. The window [night_start, night_end)
// in minutes since midnight wraps past midnight when start > end and is empty
// when they are equal. Configuration writes are always taken (ready tied high)
// and must only be issued while no item is in flight.
module night_window_mode_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	nwmc_in_if.sink     item,
	nwmc_out_if.source  result,
	nwmc_cfg_if.sink    cfg
);
	import nwmc_pkg::*;

	// configuration registers
	cfg_t cfg_regs;

	assign cfg.ready = 1'b1;

	nwmc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	// stage 1: registered input item
	logic    valid_s1;
	item_t   item_s1;
	// stage 2: registered result
	logic    valid_s2;
	result_t result_s2;
	// mode state, updated as an item moves from stage 1 into stage 2
	flags_t  flags_q;

	flags_t  flags_next;
	result_t step_res;
	logic    adv_s2;
	logic    load_s2;
	logic    take_s1;

	// result register frees when empty or when its transaction completes
	assign adv_s2  = !valid_s2 || result.ready;
	assign load_s2 = valid_s1 && adv_s2;
	// input register takes a new item when it is empty or draining this cycle
	assign item.ready = !valid_s1 || adv_s2;
	assign take_s1    = item.valid && item.ready;

	nwmc_step u_step (
		.cfg        (cfg_regs),
		.flags      (flags_q),
		.item       (item_s1),
		.flags_next (flags_next),
		.res        (step_res)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (load_s2) begin
				flags_q <= flags_next;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (take_s1) begin
			item_s1.command      <= item.command;
			item_s1.hour         <= item.hour;
			item_s1.minute       <= item.minute;
			item_s1.second       <= item.second;
			item_s1.manual_night <= item.manual_night;
		end
		if (load_s2) begin
			result_s2 <= step_res;
		end
	end

	// result channel driven straight from the result register
	assign result.valid         = valid_s2;
	assign result.night_changed = result_s2.night_changed;
	assign result.night_on      = result_s2.night_on;
	assign result.time_mark     = result_s2.time_mark;
	assign result.night_status  = result_s2.night_status;

endmodule

// ===== bench/tb_night_window_mode_controller_unit.sv =====
`timescale 1ns / 1ps

module tb_night_window_mode_controller_unit;
	import nwmc_pkg::*;

	// generous watchdog, far beyond the slowest legal run
	localparam int LIMIT_CYCLES = 200000;
	// long receiver hold-off used to fill the pipeline
	localparam int HOLD_CYCLES  = 150;
	localparam int SECS_PER_DAY = 86400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	nwmc_in_if  item_ch ();
	nwmc_out_if res_ch ();
	nwmc_cfg_if cfg_ch ();

	night_window_mode_controller_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// shadow copy of the block: registers and the two flags
	cfg_t    shadow_cfg;
	flags_t  shadow_flags;
	// results owed by the block, oldest first
	result_t expected_results[$];

	int error_count   = 0;
	int cycle_count   = 0;
	int burst_left    = 0;
	// bumped by a test to ask the receiver for a long hold-off
	int hold_requests = 0;

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	// schedule decision for a time of day; start == end means no window,
	// start > end wraps past midnight, registers used unclamped
	function automatic logic in_night_window(input logic [TOD_W-1:0] tod);
		if (shadow_cfg.night_start == shadow_cfg.night_end)
			return 1'b0;
		if (shadow_cfg.night_start < shadow_cfg.night_end)
			return (tod >= shadow_cfg.night_start) && (tod < shadow_cfg.night_end);
		return (tod >= shadow_cfg.night_start) || (tod < shadow_cfg.night_end);
	endfunction

	// advances the shadow flags by one item and returns the result it owes
	function automatic result_t predict_night_result(input item_t it);
		result_t          r;
		logic             sched;
		logic [TOD_W-1:0] tod;
		r = '0;
		if (it.command == CMD_TICK) begin
			if (shadow_cfg.auto_night) begin
				// full 11-bit minute count, out-of-range times are not wrapped
				tod = it.hour * 11'd60 + it.minute;
				sched = in_night_window(tod);
				if (sched == shadow_flags.night_flag) begin
					// schedule agrees, any manual override is over
					shadow_flags.override_pending = 1'b0;
				end else if (!shadow_flags.override_pending) begin
					shadow_flags.night_flag = sched;
					r.night_changed = 1'b1;
				end
			end
			if (it.second == '0) begin
				if (it.minute != '0)
					r.time_mark = MARK_MINUTE;
				else if (it.hour != '0)
					r.time_mark = MARK_HOUR;
				else
					r.time_mark = MARK_MIDNIGHT;
			end
		end else if (it.manual_night != shadow_flags.night_flag) begin
			// a redundant request leaves both flags alone
			shadow_flags.night_flag = it.manual_night;
			shadow_flags.override_pending = 1'b1;
			r.night_changed = 1'b1;
		end
		r.night_on = shadow_flags.night_flag;
		r.night_status = shadow_flags.night_flag & shadow_cfg.clock_valid;
		return r;
	endfunction

	function automatic item_t make_tick(input int h, input int m, input int s);
		item_t it;
		it.command = CMD_TICK;
		it.hour = h[HOUR_W-1:0];
		it.minute = m[MINUTE_W-1:0];
		it.second = s[SECOND_W-1:0];
		// ignored on a tick, toggled anyway
		it.manual_night = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic item_t make_request(input logic want_night);
		item_t it;
		// time fields are ignored on a request, so fill them with noise
		it = ($bits(item_t))'($urandom);
		it.command = CMD_MANUAL;
		it.manual_night = want_night;
		return it;
	endfunction

	// one item transaction; the sender runs in bursts with random gaps
	task automatic send_item(input item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		item_ch.valid <= 1'b1;
		item_ch.command <= it.command;
		item_ch.hour <= it.hour;
		item_ch.minute <= it.minute;
		item_ch.second <= it.second;
		item_ch.manual_night <= it.manual_night;
		@(posedge clk);
		while (item_ch.ready !== 1'b1) @(posedge clk);
		// accepted at this edge
		expected_results.push_back(predict_night_result(it));
		burst_left--;
	endtask

	// stop offering items and wait until the block owes nothing
	task automatic wait_results_drained();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		// pipeline is two deep, let it settle before going on
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		case (idx)
			REG_NIGHT_START: shadow_cfg.night_start = value;
			REG_NIGHT_END:   shadow_cfg.night_end = value;
			REG_AUTO_NIGHT:  shadow_cfg.auto_night = value[0];
			REG_CLOCK_VALID: shadow_cfg.clock_valid = value[0];
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// full register set; upper data bits of the one-bit registers get noise
	task automatic program_night_config(input int start_min, input int end_min,
			input logic auto_on, input logic clk_ok);
		wait_results_drained();
		write_reg(REG_NIGHT_START, start_min[CFG_DATA_W-1:0]);
		write_reg(REG_NIGHT_END, end_min[CFG_DATA_W-1:0]);
		write_reg(REG_AUTO_NIGHT, {10'($urandom), auto_on});
		write_reg(REG_CLOCK_VALID, {10'($urandom), clk_ok});
	endtask

	task automatic check_field(input string name, input logic [MARK_W-1:0] want,
			input logic [MARK_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endtask

	// result side: checks every transaction and drives ready on its own pattern
	initial begin : result_monitor
		int      hold_left;
		int      mode_left;
		int      stall_mode;
		int      phase_cnt;
		int      seen_holds;
		result_t got;
		result_t want;
		hold_left = 0;
		mode_left = 0;
		stall_mode = 0;
		phase_cnt = 0;
		seen_holds = 0;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				got.night_changed = res_ch.night_changed;
				got.night_on = res_ch.night_on;
				got.time_mark = res_ch.time_mark;
				got.night_status = res_ch.night_status;
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected");
					error_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("night_changed", MARK_W'(want.night_changed),
						MARK_W'(got.night_changed));
					check_field("night_on", MARK_W'(want.night_on),
						MARK_W'(got.night_on));
					check_field("time_mark", want.time_mark, got.time_mark);
					check_field("night_status", MARK_W'(want.night_status),
						MARK_W'(got.night_status));
				end
			end
			if (hold_requests != seen_holds) begin
				seen_holds = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			// pick a new stall pattern every so often
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			phase_cnt++;
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= 1'($urandom_range(0, 1));
					2: res_ch.ready <= ($urandom_range(0, 7) != 0);
					default: res_ch.ready <= (phase_cnt % 3 == 0);
				endcase
			end
		end
	end

	// reset values: empty window, auto on, clock not yet set
	task automatic test_reset_state();
		send_item(make_tick(0, 0, 0));          // midnight mark
		send_item(make_request(1'b1));          // night, status gated off
		send_item(make_tick(12, 0, 0));         // override holds night
		send_item(make_tick(12, 1, 0));         // minute mark
		send_item(make_request(1'b0));          // back to day, override set
		send_item(make_tick(12, 1, 30));        // schedule agrees, override clears
	endtask

	// window 22:00 to 06:00 wrapping past midnight
	task automatic test_wrapping_window();
		program_night_config(1320, 360, 1'b1, 1'b1);
		send_item(make_tick(21, 59, 59));
		send_item(make_tick(22, 0, 0));         // enter night on the hour mark
		send_item(make_tick(23, 59, 59));
		send_item(make_tick(0, 0, 0));          // still night over midnight
		send_item(make_tick(5, 59, 59));
		send_item(make_tick(6, 0, 0));          // end is exclusive
		send_item(make_request(1'b1));
		send_item(make_request(1'b1));          // redundant request
		send_item(make_tick(6, 0, 1));          // override keeps night
		send_item(make_request(1'b0));
		send_item(make_tick(22, 30, 0));        // override blocks the schedule
		send_item(make_tick(6, 30, 0));         // agreement clears override
	endtask

	// unclamped registers and out-of-range time fields
	task automatic test_window_extremes();
		program_night_config(0, 2047, 1'b1, 1'b1);
		send_item(make_tick(31, 63, 63));       // 1923 minutes, inside
		program_night_config(2047, 0, 1'b1, 1'b0);
		send_item(make_tick(31, 63, 0));        // wrap that never matches
		send_item(make_tick(16, 32, 32));
	endtask

	// with auto switching off the schedule is ignored
	task automatic test_auto_off();
		program_night_config(600, 700, 1'b0, 1'b1);
		send_item(make_tick(10, 30, 0));
		send_item(make_request(1'b1));
		program_night_config(600, 700, 1'b1, 1'b1);
		send_item(make_tick(10, 31, 0));
	endtask

	// window placed near a running time of day, or at the extremes
	task automatic pick_random_config(input int secs);
		int now_min;
		int start_min;
		int end_min;
		now_min = secs / 60;
		case ($urandom_range(0, 5))
			0, 1: begin
				start_min = (now_min + $urandom_range(0, 6)) % 1440;
				end_min = (start_min + $urandom_range(1, 10)) % 1440;
			end
			2: begin
				// straddles midnight
				start_min = 1440 - $urandom_range(1, 5);
				end_min = $urandom_range(0, 5);
			end
			3: begin
				start_min = $urandom_range(0, 1439);
				end_min = start_min;
			end
			4: begin
				case ($urandom_range(0, 3))
					0: begin start_min = 0;    end_min = 1439; end
					1: begin start_min = 1439; end_min = 0;    end
					2: begin start_min = 2047; end_min = 0;    end
					default: begin start_min = 0; end_min = 2047; end
				endcase
			end
			default: begin
				start_min = $urandom_range(0, 2047);
				end_min = $urandom_range(0, 2047);
			end
		endcase
		program_night_config(start_min, end_min, $urandom_range(0, 4) != 0,
			1'($urandom_range(0, 1)));
	endtask

	function automatic int advance_clock(input int secs);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: secs = secs + 1;
			5, 6, 7: secs = (secs / 60 + $urandom_range(1, 3)) * 60;
			8: secs = (secs / 3600 + 1) * 3600;
			default: secs = secs + $urandom_range(60, 600);
		endcase
		return secs % SECS_PER_DAY;
	endfunction

	// mostly a running clock with manual requests, some raw noise
	task automatic send_clock_stream(inout int secs, input int count);
		int    roll;
		item_t it;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 14) begin
				send_item(make_request(1'($urandom_range(0, 1))));
			end else if (roll < 20) begin
				it = ($bits(item_t))'($urandom);
				send_item(it);
			end else begin
				secs = advance_clock(secs);
				send_item(make_tick(secs / 3600, (secs / 60) % 60, secs % 60));
			end
		end
	endtask

	task automatic test_random_schedule();
		int secs;
		for (int p = 0; p < 10; p++) begin
			if ($urandom_range(0, 3) == 0)
				secs = 23 * 3600 + 58 * 60 + $urandom_range(0, 59);
			else
				secs = $urandom_range(0, SECS_PER_DAY - 1);
			pick_random_config(secs);
			send_clock_stream(secs, 45);
		end
	endtask

	// receiver holds off while items keep coming, so the input stalls
	task automatic test_backpressure();
		int secs;
		secs = $urandom_range(0, SECS_PER_DAY - 1);
		pick_random_config(secs);
		hold_requests <= hold_requests + 1;
		send_clock_stream(secs, 40);
		wait_results_drained();
	endtask

	initial begin
		item_ch.valid <= 1'b0;
		item_ch.command <= CMD_TICK;
		item_ch.hour <= '0;
		item_ch.minute <= '0;
		item_ch.second <= '0;
		item_ch.manual_night <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_NIGHT_START;
		cfg_ch.data <= '0;
		shadow_cfg.night_start = '0;
		shadow_cfg.night_end = '0;
		shadow_cfg.auto_night = 1'b1;
		shadow_cfg.clock_valid = 1'b0;
		shadow_flags = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_wrapping_window();
		test_window_extremes();
		test_auto_off();
		test_random_schedule();
		test_backpressure();

		wait_results_drained();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
